@@ hw/rtl/kjc_pkg.sv @@
// ----------------------------------------------------------------------------
// kjc_pkg
// Shared types, register offsets and command codes of the keyboard and
// joystick port block.
// ----------------------------------------------------------------------------
package kjc_pkg;

	localparam int KEY_ROWS       = 8;
	localparam int JOYSTICK_COUNT = 2;
	localparam int ROW_W          = $clog2(KEY_ROWS);
	localparam int JOY_W          = $clog2(JOYSTICK_COUNT);
	localparam int PERIOD_W       = 20;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(16700);
	localparam logic [7:0]          BYTE_ONES    = 8'hFF;

	// commands
	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_TICK  = 3'd2;
	localparam logic [2:0] CMD_KEY   = 3'd3;
	localparam logic [2:0] CMD_JOY   = 3'd4;

	// register offsets inside the window
	localparam logic [7:0] OFF_PORT_A = 8'h00;
	localparam logic [7:0] OFF_PORT_B = 8'h01;
	localparam logic [7:0] OFF_DDR_A  = 8'h02;
	localparam logic [7:0] OFF_DDR_B  = 8'h03;
	localparam logic [7:0] OFF_ICR    = 8'h0D;
	localparam logic [7:0] OFF_CRA    = 8'h0E;

	// interrupt and timer control bits
	localparam int ICR_SET_BIT   = 7;
	localparam int ICR_TIMER_BIT = 0;
	localparam int CRA_START_BIT = 0;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] reg_offset;
		logic [7:0] write_data;
		logic [3:0] key_row;
		logic [2:0] key_column;
		logic       pressed;
		logic [1:0] joystick_index;
		logic [2:0] button_index;
	} kjc_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic       error;
	} kjc_result_t;

	typedef logic [KEY_ROWS-1:0][7:0]       kjc_matrix_t;
	typedef logic [JOYSTICK_COUNT-1:0][7:0] kjc_joy_t;

endpackage

@@ hw/rtl/kjc_if.sv @@
// ----------------------------------------------------------------------------
// kjc channel interfaces
// Valid/ready channels for input items, result items and the period register.
// ----------------------------------------------------------------------------
interface kjc_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] reg_offset;
	logic [7:0] write_data;
	logic [3:0] key_row;
	logic [2:0] key_column;
	logic       pressed;
	logic [1:0] joystick_index;
	logic [2:0] button_index;

	modport source (output valid, command, reg_offset, write_data, key_row, key_column,
		pressed, joystick_index, button_index, input ready);
	modport sink (input valid, command, reg_offset, write_data, key_row, key_column,
		pressed, joystick_index, button_index, output ready);
endinterface

interface kjc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq;
	logic       error;

	modport source (output valid, read_data, irq, error, input ready);
	modport sink (input valid, read_data, irq, error, output ready);
endinterface

interface kjc_cfg_if;
	logic        valid;
	logic        ready;
	logic [19:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/kjc_scan.sv @@
// ----------------------------------------------------------------------------
// kjc_scan
// Port B read value: key rows selected by port A merged with joystick 0.
// ----------------------------------------------------------------------------
module kjc_scan (
	input  logic [7:0]          port_a,
	input  logic [7:0]          direction_b,
	input  kjc_pkg::kjc_matrix_t key_matrix,
	input  logic [7:0]          joy0,
	output logic [7:0]          scan_data
);
	import kjc_pkg::*;

	logic [ROW_W-1:0] sel_row;
	logic [7:0]       all_rows;

	// find the highest clear bit of port A
	always_comb begin
		sel_row = '0;
		for (int i = 0; i < 8; i++) begin
			if (!port_a[i]) begin
				sel_row = ROW_W'(i);
			end
		end
	end

	// AND of every row
	always_comb begin
		all_rows = BYTE_ONES;
		for (int r = 0; r < KEY_ROWS; r++) begin
			all_rows = all_rows & key_matrix[r];
		end
	end

	// pick the scan result
	always_comb begin
		if (direction_b != 8'h00) begin
			scan_data = BYTE_ONES;
		end else if (port_a == BYTE_ONES) begin
			scan_data = joy0;
		end else if (port_a == 8'h00) begin
			scan_data = all_rows & joy0;
		end else begin
			scan_data = key_matrix[sel_row] & joy0;
		end
	end

endmodule

@@ hw/rtl/kjc_state.sv @@
// ----------------------------------------------------------------------------
// kjc_state
// Chip state and the single-pass update for one item; gives the result.
// ----------------------------------------------------------------------------
module kjc_state (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       update,
	input  kjc_pkg::kjc_item_t         item_s1,
	input  logic [kjc_pkg::PERIOD_W-1:0] tick_period,
	output kjc_pkg::kjc_result_t       result_d
);
	import kjc_pkg::*;

	logic [7:0]          port_a_q, port_b_q, dir_a_q, dir_b_q;
	kjc_matrix_t         keys_q;
	kjc_joy_t            joy_q;
	logic                running_q, expired_q, enable_q, irq_q;
	logic [PERIOD_W-1:0] elapsed_q;

	logic [7:0]          port_a_d, port_b_d, dir_a_d, dir_b_d;
	kjc_matrix_t         keys_d;
	kjc_joy_t            joy_d;
	logic                running_d, expired_d, enable_d, irq_d;
	logic [PERIOD_W-1:0] elapsed_d, elapsed_inc;
	logic [7:0]          scan_data;
	logic [7:0]          rd;
	logic                err;

	kjc_scan u_scan (
		.port_a      (port_a_q),
		.direction_b (dir_b_q),
		.key_matrix  (keys_q),
		.joy0        (joy_q[0]),
		.scan_data   (scan_data)
	);

	assign elapsed_inc = elapsed_q + PERIOD_W'(1);

	// next state and result for the item in stage 1
	always_comb begin
		port_a_d  = port_a_q;
		port_b_d  = port_b_q;
		dir_a_d   = dir_a_q;
		dir_b_d   = dir_b_q;
		keys_d    = keys_q;
		joy_d     = joy_q;
		running_d = running_q;
		expired_d = expired_q;
		enable_d  = enable_q;
		irq_d     = irq_q;
		elapsed_d = elapsed_q;
		rd        = 8'h00;
		err       = 1'b0;
		case (item_s1.command)
			CMD_READ: begin
				case (item_s1.reg_offset)
					OFF_PORT_A: rd = joy_q[1];
					OFF_PORT_B: rd = scan_data;
					OFF_DDR_A:  rd = dir_a_q;
					OFF_DDR_B:  rd = dir_b_q;
					OFF_ICR:    expired_d = 1'b0;
					default:    rd = 8'h00;
				endcase
			end
			CMD_WRITE: begin
				case (item_s1.reg_offset)
					OFF_PORT_A: begin
						if (dir_a_q == BYTE_ONES) port_a_d = item_s1.write_data;
					end
					OFF_PORT_B: begin
						if (dir_b_q == BYTE_ONES) port_b_d = item_s1.write_data;
					end
					OFF_DDR_A: dir_a_d = item_s1.write_data;
					OFF_DDR_B: dir_b_d = item_s1.write_data;
					OFF_ICR: begin
						if (item_s1.write_data[ICR_SET_BIT]) begin
							enable_d = item_s1.write_data[ICR_TIMER_BIT];
						end else if (item_s1.write_data[ICR_TIMER_BIT]) begin
							enable_d = 1'b0;
						end
					end
					OFF_CRA: begin
						running_d = item_s1.write_data[CRA_START_BIT];
						if (item_s1.write_data[CRA_START_BIT]) elapsed_d = '0;
					end
					default: rd = 8'h00;
				endcase
			end
			CMD_TICK: begin
				if (running_q) begin
					if (elapsed_inc >= tick_period) begin
						expired_d = 1'b1;
						elapsed_d = '0;
					end else begin
						elapsed_d = elapsed_inc;
					end
				end
				irq_d = enable_q && running_q && expired_d;
			end
			CMD_KEY: begin
				if (item_s1.key_row >= 4'(KEY_ROWS)) begin
					err = 1'b1;
				end else begin
					keys_d[item_s1.key_row[ROW_W-1:0]][item_s1.key_column] = !item_s1.pressed;
				end
			end
			CMD_JOY: begin
				if (item_s1.joystick_index >= 2'(JOYSTICK_COUNT)) begin
					err = 1'b1;
				end else begin
					joy_d[item_s1.joystick_index[JOY_W-1:0]][item_s1.button_index] =
						!item_s1.pressed;
				end
			end
			default: err = 1'b0;
		endcase
	end

	assign result_d.read_data = rd;
	assign result_d.irq       = irq_d;
	assign result_d.error     = err;

	// commit state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q  <= BYTE_ONES;
			port_b_q  <= BYTE_ONES;
			dir_a_q   <= BYTE_ONES;
			dir_b_q   <= BYTE_ONES;
			keys_q    <= {KEY_ROWS{BYTE_ONES}};
			joy_q     <= {JOYSTICK_COUNT{BYTE_ONES}};
			running_q <= 1'b0;
			expired_q <= 1'b0;
			enable_q  <= 1'b0;
			irq_q     <= 1'b0;
			elapsed_q <= '0;
		end else if (update) begin
			port_a_q  <= port_a_d;
			port_b_q  <= port_b_d;
			dir_a_q   <= dir_a_d;
			dir_b_q   <= dir_b_d;
			keys_q    <= keys_d;
			joy_q     <= joy_d;
			running_q <= running_d;
			expired_q <= expired_d;
			enable_q  <= enable_d;
			irq_q     <= irq_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

@@ hw/rtl/keyboard_joystick_cia_port_core.sv @@
// ----------------------------------------------------------------------------
// keyboard_joystick_cia_port_core
// Keyboard and joystick port block: input register, single-pass state update,
// result register.
//
//   channel  role   beat contents
//   item     sink   command, offset, write byte, key and joystick event fields
//   result   source read_data, irq, error (one beat per item)
//   cfg      sink   tick_period write data, always ready
//
// An accepted item passes through the input register, then the result register,
// before its result beat. One item is accepted every cycle while the result
// side takes beats. A stalled result holds the result register and then the
// input register; item ready drops only when both are full. Reset restores the
// port state and the valid flags at once; tick_period returns to 16700.
// ----------------------------------------------------------------------------
module keyboard_joystick_cia_port_core (
	input  logic         clk,
	input  logic         arst_n,
	kjc_item_if.sink     item,
	kjc_result_if.source result,
	kjc_cfg_if.sink      cfg
);
	import kjc_pkg::*;

	kjc_item_t           item_s1;
	logic                valid_s1;
	kjc_result_t         res_s2;
	logic                valid_s2;
	kjc_result_t         result_d;
	logic                advance;
	logic [PERIOD_W-1:0] period_q;

	// stage 1 moves on when the result register is free or draining
	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg.valid) begin
			period_q <= cfg.data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.command        <= item.command;
			item_s1.reg_offset     <= item.reg_offset;
			item_s1.write_data     <= item.write_data;
			item_s1.key_row        <= item.key_row;
			item_s1.key_column     <= item.key_column;
			item_s1.pressed        <= item.pressed;
			item_s1.joystick_index <= item.joystick_index;
			item_s1.button_index   <= item.button_index;
		end
	end

	kjc_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.update      (advance && valid_s1),
		.item_s1     (item_s1),
		.tick_period (period_q),
		.result_d    (result_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= result_d;
		end
	end

	assign result.valid     = valid_s2;
	assign result.read_data = res_s2.read_data;
	assign result.irq       = res_s2.irq;
	assign result.error     = res_s2.error;

endmodule

@@ hw/rtl/kjc_checker.sv @@
// ----------------------------------------------------------------------------
// kjc_checker
// Port-level checks on the keyboard and joystick port block.
// ----------------------------------------------------------------------------
module kjc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] read_data,
	input logic       irq,
	input logic       error
);

	// hold a stalled result beat
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable({read_data, irq, error}))
		else $error("result beat changed while stalled");

	// an error beat comes from an event command and carries no read byte
	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error |-> read_data == 8'h00)
		else $error("error beat with read data");

	// an empty result register never blocks the item side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item ready low with empty result register");

	// no result beat during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind keyboard_joystick_cia_port_core kjc_checker u_kjc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.read_data    (result.read_data),
	.irq          (result.irq),
	.error        (result.error)
);

@@ test/keyboard_joystick_cia_port_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_joystick_cia_port_core_tb
// Self-checking bench for the keyboard and joystick port block. A clocked
// driver plays bus reads and writes, ticks and key or joystick events from a
// backlog; a clocked monitor compares every result beat against a port model
// kept in this file. Both channels idle at random. The tick period is
// reprogrammed between phases, from zero up to the largest value.
// ----------------------------------------------------------------------------
module keyboard_joystick_cia_port_core_tb;
	import kjc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 80;

	logic clk;
	logic arst_n;

	kjc_item_if   item_ch ();
	kjc_result_if res_ch ();
	kjc_cfg_if    cfg_ch ();

	keyboard_joystick_cia_port_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// port model state
	logic [PERIOD_W-1:0] tmr_period = PERIOD_RESET;
	logic [7:0]          pa_latch   = BYTE_ONES;
	logic [7:0]          pb_latch   = BYTE_ONES;
	logic [7:0]          ddr_a      = BYTE_ONES;
	logic [7:0]          ddr_b      = BYTE_ONES;
	kjc_matrix_t         keys       = '1;
	kjc_joy_t            joys       = '1;
	logic                tmr_run    = 1'b0;
	logic                tmr_flag   = 1'b0;
	logic                tmr_irq_en = 1'b0;
	logic [PERIOD_W-1:0] tmr_count  = '0;
	logic                irq_level  = 1'b0;

	kjc_item_t   bus_backlog[$];
	kjc_result_t port_replies[$];

	int  fails = 0;
	int  items_in = 0;
	int  cycles = 0;
	int  n_reads = 0, n_ticks = 0, n_events = 0, n_rejects = 0, n_irq = 0, n_periods = 0;
	logic calm;

	// one long stretch with both sides running flat out
	assign calm = (items_in >= 200) && (items_in < 320);

	// advance the port model by one item and return the result it gives
	function automatic kjc_result_t port_step(kjc_item_t it);
		kjc_result_t r;
		logic [7:0]  v;
		logic [7:0]  sel;
		int          row;
		r = '0;
		case (it.command)
			CMD_READ: begin
				n_reads++;
				case (it.reg_offset)
					OFF_PORT_A: r.read_data = joys[1];
					OFF_PORT_B: begin
						if (ddr_b != 8'h00) begin
							r.read_data = BYTE_ONES;
						end else if (pa_latch == BYTE_ONES) begin
							r.read_data = joys[0];
						end else if (pa_latch == 8'h00) begin
							v = BYTE_ONES;
							for (int i = 0; i < KEY_ROWS; i++)
								v &= keys[i];
							r.read_data = v & joys[0];
						end else begin
							// row is the highest clear bit of port A
							sel = ~pa_latch;
							row = 0;
							for (int b = 0; b < 8; b++)
								if (sel[b])
									row = b;
							r.read_data = keys[row] & joys[0];
						end
					end
					OFF_DDR_A: r.read_data = ddr_a;
					OFF_DDR_B: r.read_data = ddr_b;
					OFF_ICR:   tmr_flag = 1'b0;
					default:   r.read_data = 8'h00;
				endcase
			end
			CMD_WRITE: begin
				case (it.reg_offset)
					OFF_PORT_A: if (ddr_a == BYTE_ONES) pa_latch = it.write_data;
					OFF_PORT_B: if (ddr_b == BYTE_ONES) pb_latch = it.write_data;
					OFF_DDR_A:  ddr_a = it.write_data;
					OFF_DDR_B:  ddr_b = it.write_data;
					OFF_ICR: begin
						if (it.write_data[ICR_SET_BIT])
							tmr_irq_en = it.write_data[ICR_TIMER_BIT];
						else if (it.write_data[ICR_TIMER_BIT])
							tmr_irq_en = 1'b0;
					end
					OFF_CRA: begin
						tmr_run = it.write_data[CRA_START_BIT];
						if (tmr_run)
							tmr_count = '0;
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				n_ticks++;
				if (tmr_run) begin
					tmr_count = tmr_count + 1'b1;
					if (tmr_count >= tmr_period) begin
						tmr_flag  = 1'b1;
						tmr_count = '0;
					end
				end
				irq_level = tmr_irq_en & tmr_run & tmr_flag;
			end
			CMD_KEY: begin
				n_events++;
				if (it.key_row >= KEY_ROWS)
					r.error = 1'b1;
				else
					keys[it.key_row[ROW_W-1:0]][it.key_column] = ~it.pressed;
			end
			CMD_JOY: begin
				n_events++;
				if (it.joystick_index >= JOYSTICK_COUNT)
					r.error = 1'b1;
				else
					joys[it.joystick_index[JOY_W-1:0]][it.button_index] = ~it.pressed;
			end
			default: ;
		endcase
		r.irq = irq_level;
		if (r.error)
			n_rejects++;
		if (r.irq)
			n_irq++;
		return r;
	endfunction

	// bus access with the event fields left random
	function automatic kjc_item_t bus_op(logic [2:0] cmd, logic [7:0] off, logic [7:0] data);
		kjc_item_t it;
		it = kjc_item_t'({$urandom, $urandom});
		it.command    = cmd;
		it.reg_offset = off;
		it.write_data = data;
		return it;
	endfunction

	// key or joystick event; sel is the row or joystick, pos the column or button
	function automatic kjc_item_t input_evt(logic [2:0] cmd, logic [3:0] sel, logic [2:0] pos,
		logic down);
		kjc_item_t it;
		it = kjc_item_t'({$urandom, $urandom});
		it.command        = cmd;
		it.key_row        = sel;
		it.key_column     = pos;
		it.joystick_index = sel[1:0];
		it.button_index   = pos;
		it.pressed        = down;
		return it;
	endfunction

	// random item weighted toward sequences that reach the scan and timer logic
	function automatic kjc_item_t random_op();
		kjc_item_t  it;
		int         pick;
		logic [7:0] off;
		logic [7:0] data;
		it   = kjc_item_t'({$urandom, $urandom});
		pick = $urandom_range(99);
		case ($urandom_range(7))
			0:       off = OFF_PORT_A;
			1, 2:    off = OFF_PORT_B;
			3:       off = OFF_DDR_A;
			4:       off = OFF_DDR_B;
			5:       off = OFF_ICR;
			6:       off = OFF_CRA;
			default: off = 8'($urandom);
		endcase
		data = 8'($urandom);
		if (pick < 25) begin
			it.command = CMD_TICK;
		end else if (pick < 45) begin
			it.command    = CMD_READ;
			it.reg_offset = off;
		end else if (pick < 65) begin
			it.command    = CMD_WRITE;
			it.reg_offset = off;
			case (off)
				OFF_PORT_A: begin
					case ($urandom_range(3))
						0: data = 8'h00;
						1: data = BYTE_ONES;
						2: data = ~(8'h01 << $urandom_range(7));
						default: ;
					endcase
				end
				OFF_DDR_A: if ($urandom_range(3) != 0) data = BYTE_ONES;
				OFF_DDR_B: if ($urandom_range(3) != 0) data = 8'h00;
				OFF_ICR: begin
					case ($urandom_range(4))
						0: data = 8'h81;
						1: data = 8'h80;
						2: data = 8'h01;
						3: data = 8'h00;
						default: ;
					endcase
				end
				OFF_CRA: if ($urandom_range(9) < 7) data = 8'h01;
				default: ;
			endcase
			it.write_data = data;
		end else if (pick < 80) begin
			it.command = CMD_KEY;
			if ($urandom_range(9) != 0)
				it.key_row = 4'($urandom_range(KEY_ROWS - 1));
		end else if (pick < 93) begin
			it.command = CMD_JOY;
			if ($urandom_range(6) != 0)
				it.joystick_index = 2'($urandom_range(JOYSTICK_COUNT - 1));
		end else if (pick < 97) begin
			it.command = 3'($urandom_range(5, 7));
		end
		return it;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fails++;
	endtask

	// wait until the port is empty, then let the pipeline settle
	task automatic drain();
		do
			@(negedge clk);
		while (bus_backlog.size() != 0 || item_ch.valid || port_replies.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// write the tick period, then hold until the beat is taken
	task automatic set_period(logic [PERIOD_W-1:0] p);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= p;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		tmr_period = p;
		n_periods++;
		@(negedge clk);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// known levels before the first edge
	initial begin
		item_ch.valid          = 1'b0;
		item_ch.command        = CMD_READ;
		item_ch.reg_offset     = 8'h00;
		item_ch.write_data     = 8'h00;
		item_ch.key_row        = 4'h0;
		item_ch.key_column     = 3'h0;
		item_ch.pressed        = 1'b0;
		item_ch.joystick_index = 2'h0;
		item_ch.button_index   = 3'h0;
		res_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.data            = '0;
	end

	// driver: predict each accepted beat, then present the next one or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				port_replies.push_back(port_step(kjc_item_t'{
					item_ch.command, item_ch.reg_offset, item_ch.write_data,
					item_ch.key_row, item_ch.key_column, item_ch.pressed,
					item_ch.joystick_index, item_ch.button_index}));
				items_in++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (bus_backlog.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
					{item_ch.command, item_ch.reg_offset, item_ch.write_data,
						item_ch.key_row, item_ch.key_column, item_ch.pressed,
						item_ch.joystick_index, item_ch.button_index} <= bus_backlog.pop_front();
					item_ch.valid <= 1'b1;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest prediction
	always @(posedge clk) begin : result_check
		kjc_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (port_replies.size() == 0) begin
					report_mismatch("result beat with no item outstanding");
				end else begin
					want = port_replies.pop_front();
					if (res_ch.read_data !== want.read_data)
						report_mismatch($sformatf("read_data %02h, want %02h",
							res_ch.read_data, want.read_data));
					if (res_ch.irq !== want.irq)
						report_mismatch($sformatf("irq %b, want %b", res_ch.irq, want.irq));
					if (res_ch.error !== want.error)
						report_mismatch($sformatf("error %b, want %b",
							res_ch.error, want.error));
				end
			end
			res_ch.ready <= calm || ($urandom_range(99) >= 31);
		end
	end

	// drop the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, port_replies.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin : stimulus
		logic [PERIOD_W-1:0] periods[6];
		// assert reset just after time zero so the asynchronous clear sees an edge
		arst_n = 1'b1;
		#1 arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short period so the directed part sees the flag set
		set_period(PERIOD_W'(2));

		// directed: scan modes, range errors, timer flag and interrupt
		bus_backlog.push_back(bus_op(CMD_READ, OFF_PORT_B, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_DDR_B, 8'h00));
		bus_backlog.push_back(input_evt(CMD_KEY, 4'd0, 3'd0, 1'b1));
		bus_backlog.push_back(input_evt(CMD_KEY, 4'd7, 3'd7, 1'b1));
		bus_backlog.push_back(input_evt(CMD_KEY, 4'd15, 3'd3, 1'b1));
		bus_backlog.push_back(input_evt(CMD_JOY, 4'd0, 3'd7, 1'b1));
		bus_backlog.push_back(input_evt(CMD_JOY, 4'd1, 3'd0, 1'b1));
		bus_backlog.push_back(input_evt(CMD_JOY, 4'd3, 3'd2, 1'b1));
		bus_backlog.push_back(bus_op(CMD_READ, OFF_PORT_B, 8'h00));
		bus_backlog.push_back(bus_op(CMD_READ, OFF_PORT_A, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_PORT_A, 8'h00));
		bus_backlog.push_back(bus_op(CMD_READ, OFF_PORT_B, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_PORT_A, 8'h7F));
		bus_backlog.push_back(bus_op(CMD_READ, OFF_PORT_B, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_DDR_A, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_PORT_A, 8'hFE));
		bus_backlog.push_back(bus_op(CMD_READ, OFF_PORT_B, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_DDR_A, BYTE_ONES));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_ICR, 8'h81));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_CRA, 8'h01));
		bus_backlog.push_back(bus_op(CMD_TICK, 8'h00, 8'h00));
		bus_backlog.push_back(bus_op(CMD_TICK, 8'h00, 8'h00));
		bus_backlog.push_back(bus_op(CMD_READ, OFF_ICR, 8'h00));
		bus_backlog.push_back(bus_op(CMD_TICK, 8'h00, 8'h00));
		bus_backlog.push_back(bus_op(CMD_WRITE, OFF_ICR, 8'h01));
		bus_backlog.push_back(bus_op(3'd7, 8'h00, 8'h00));
		bus_backlog.push_back(bus_op(CMD_READ, 8'hFF, 8'h00));
		drain();

		// random phases, one tick period each, extremes included
		periods[0] = '0;
		periods[1] = PERIOD_W'(1);
		periods[2] = PERIOD_W'(3);
		periods[3] = '1;
		periods[4] = PERIOD_W'(7);
		periods[5] = PERIOD_W'($urandom_range(2, 12));
		foreach (periods[p]) begin
			set_period(periods[p]);
			for (int n = 0; n < PHASE_ITEMS; n++)
				bus_backlog.push_back(random_op());
			drain();
		end

		repeat (4) @(posedge clk);
		$display("covered %0d items over %0d tick periods: %0d reads, %0d ticks, %0d events",
			items_in, n_periods, n_reads, n_ticks, n_events);
		$display("  %0d rejected events, %0d results with irq high, %0d mismatches",
			n_rejects, n_irq, fails);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
